/* hw/rtl/lli_pkg.sv */
// Shared constants for the line intersection datapath.
`timescale 1ns / 1ps
package lli_pkg;
  localparam int IN_W = 16;
  localparam int OUT_W = 32;
  localparam int QBITS = 32;
  localparam int CROSS_FRAC = 8;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int LANES = 2;

  typedef struct packed {
    logic valid;
  } ctl_t;
endpackage

/* hw/rtl/lli_div_cell.sv */
// One restoring-division step for two lanes, registered, with sideband.
`timescale 1ns / 1ps
module lli_div_cell #(
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  lli_pkg::ctl_t                                    ctl_i,
  input  logic [lli_pkg::LANES-1:0][DW-1:0]                r_i,
  input  logic [lli_pkg::LANES-1:0][lli_pkg::QBITS-1:0]    nq_i,
  input  logic [DW-1:0]                                    d_i [lli_pkg::LANES],
  input  logic [SW-1:0]                                    side_i,
  output lli_pkg::ctl_t                                    ctl_o,
  output logic [lli_pkg::LANES-1:0][DW-1:0]                r_o,
  output logic [lli_pkg::LANES-1:0][lli_pkg::QBITS-1:0]    nq_o,
  output logic [DW-1:0]                                    d_o [lli_pkg::LANES],
  output logic [SW-1:0]                                    side_o
);
  logic [lli_pkg::LANES-1:0][DW-1:0] r_nxt;
  logic [lli_pkg::LANES-1:0][lli_pkg::QBITS-1:0] nq_nxt;
  lli_pkg::ctl_t ctl_r;
  logic [lli_pkg::LANES-1:0][DW-1:0] r_r;
  logic [lli_pkg::LANES-1:0][lli_pkg::QBITS-1:0] nq_r;
  logic [DW-1:0] d_r [lli_pkg::LANES];
  logic [SW-1:0] side_r;

  always_comb begin
    logic [DW:0] t;
    logic [DW:0] dd;
    r_nxt = '0;
    nq_nxt = '0;
    for (int l = 0; l < lli_pkg::LANES; l++) begin
      t = {r_i[l], nq_i[l][lli_pkg::QBITS-1]};
      dd = {1'b0, d_i[l]};
      if (t >= dd) begin
        r_nxt[l] = DW'(t - dd);
        nq_nxt[l] = {nq_i[l][lli_pkg::QBITS-2:0], 1'b1};
      end else begin
        r_nxt[l] = t[DW-1:0];
        nq_nxt[l] = {nq_i[l][lli_pkg::QBITS-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    r_r <= r_nxt;
    nq_r <= nq_nxt;
    d_r <= d_i;
    side_r <= side_i;
  end

  assign ctl_o = ctl_r;
  assign r_o = r_r;
  assign nq_o = nq_r;
  assign d_o = d_r;
  assign side_o = side_r;
endmodule

/* hw/rtl/lli_div_chain.sv */
// Row of division cells giving a truncated quotient per lane.
`timescale 1ns / 1ps
module lli_div_chain #(
  parameter int DW = 8,
  parameter int SW = 1
) (
  input  logic                                             clk,
  input  logic                                             rst_n,
  input  lli_pkg::ctl_t                                    ctl_i,
  input  logic [lli_pkg::LANES-1:0][DW-1:0]                r_i,
  input  logic [lli_pkg::LANES-1:0][lli_pkg::QBITS-1:0]    nq_i,
  input  logic [DW-1:0]                                    d_i [lli_pkg::LANES],
  input  logic [SW-1:0]                                    side_i,
  output lli_pkg::ctl_t                                    ctl_o,
  output logic [lli_pkg::LANES-1:0][lli_pkg::QBITS-1:0]    q_o,
  output logic [SW-1:0]                                    side_o
);
  localparam int N = lli_pkg::QBITS;

  lli_pkg::ctl_t ctl_w [N+1];
  logic [lli_pkg::LANES-1:0][DW-1:0] r_w [N+1];
  logic [lli_pkg::LANES-1:0][lli_pkg::QBITS-1:0] nq_w [N+1];
  logic [DW-1:0] d_w [N+1][lli_pkg::LANES];
  logic [SW-1:0] side_w [N+1];

  assign ctl_w[0] = ctl_i;
  assign r_w[0] = r_i;
  assign nq_w[0] = nq_i;
  assign d_w[0] = d_i;
  assign side_w[0] = side_i;

  for (genvar k = 0; k < N; k++) begin : g_cell
    lli_div_cell #(.DW(DW), .SW(SW)) u_cell (
      .clk(clk), .rst_n(rst_n),
      .ctl_i(ctl_w[k]), .r_i(r_w[k]), .nq_i(nq_w[k]), .d_i(d_w[k]), .side_i(side_w[k]),
      .ctl_o(ctl_w[k+1]), .r_o(r_w[k+1]), .nq_o(nq_w[k+1]), .d_o(d_w[k+1]),
      .side_o(side_w[k+1])
    );
  end

  assign ctl_o = ctl_w[N];
  assign q_o = nq_w[N];
  assign side_o = side_w[N];
endmodule

/* hw/rtl/line_intersection_with_params_unit.sv */
// Line-line intersection by Cramer's rule with projection parameters.
// Throughput: one beat per cycle; busy stays low, the pipeline never stalls.
// Cost is set by two rows of 32 division cells (crossing, then projection).
// Synchronous active-low reset clears all valid flags; payload is not reset.
`timescale 1ns / 1ps
module line_intersection_with_params_unit #(
  parameter int COORD_BITS = lli_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS = lli_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [lli_pkg::IN_W-1:0]   in_a_start_x,
  input  logic signed [lli_pkg::IN_W-1:0]   in_a_start_y,
  input  logic signed [lli_pkg::IN_W-1:0]   in_a_end_x,
  input  logic signed [lli_pkg::IN_W-1:0]   in_a_end_y,
  input  logic signed [lli_pkg::IN_W-1:0]   in_b_start_x,
  input  logic signed [lli_pkg::IN_W-1:0]   in_b_start_y,
  input  logic signed [lli_pkg::IN_W-1:0]   in_b_end_x,
  input  logic signed [lli_pkg::IN_W-1:0]   in_b_end_y,
  output logic                              out_valid,
  output logic                              out_found,
  output logic signed [lli_pkg::OUT_W-1:0]  out_cross_x,
  output logic signed [lli_pkg::OUT_W-1:0]  out_cross_y,
  output logic signed [lli_pkg::OUT_W-1:0]  out_param_a,
  output logic signed [lli_pkg::OUT_W-1:0]  out_param_b,
  output logic                              out_saturated
);
  localparam int QB = lli_pkg::QBITS;
  localparam int CF = lli_pkg::CROSS_FRAC;
  localparam int CW = (COORD_BITS > lli_pkg::IN_W) ? lli_pkg::IN_W + 1 : COORD_BITS;
  localparam int DA = CW + 1;
  localparam int P2W = 2 * DA;
  localparam int DETW = 2 * DA + 1;
  localparam int D1W = 2 * CW + 1;
  localparam int P4W = D1W + DA;
  localparam int AXW = P4W + 1;
  localparam int NCW = (AXW + CF > QB + 1) ? AXW + CF : QB + 1;
  localparam int HXW = NCW - QB;
  localparam int CXW = (HXW > DETW) ? HXW : DETW;
  localparam int VW = (CW + CF + 1 > lli_pkg::OUT_W + 1) ? CW + CF + 1 : lli_pkg::OUT_W + 1;
  localparam int PDW = DA + VW;
  localparam int DOTW = PDW + 1;
  localparam int QLW = 2 * DA + 1;
  localparam int QDW = 2 * DA + CF;
  localparam int NPW = (DOTW + FRAC_BITS > QB + 1) ? DOTW + FRAC_BITS : QB + 1;
  localparam int HPW = NPW - QB;
  localparam int CPW = (HPW > QDW) ? HPW : QDW;
  localparam int SW1 = 5 + 8 * CW;
  localparam int SW2 = 6 + 2 * lli_pkg::OUT_W;
  localparam int LAT = 9 + 2 * QB;

  function automatic logic [CW-1:0] crd(input logic [lli_pkg::IN_W-1:0] raw);
    logic [lli_pkg::IN_W:0] ext;
    ext = {1'b0, raw};
    return ext[CW-1:0];
  endfunction

  function automatic logic [lli_pkg::OUT_W:0] sat32(input logic [QB-1:0] q, input logic neg,
                                                    input logic ovf);
    logic [QB-1:0] lim;
    lim = {1'b1, {(QB-1){1'b0}}};
    if (neg) begin
      if (ovf || q > lim) return {1'b1, lim};
      return {1'b0, -q};
    end
    if (ovf || q[QB-1]) return {1'b1, ~lim};
    return {1'b0, q};
  endfunction

  // s1: capture
  logic v1_r;
  logic [7:0][CW-1:0] c1_r;
  // s2: differences and first products
  logic v2_r;
  logic [7:0][CW-1:0] c2_r;
  logic signed [DA-1:0] dax, day, dbx, dby;
  logic signed [DA-1:0] dax2_r, day2_r, dbx2_r, dby2_r;
  logic signed [P2W-1:0] p0_r, p1_r;
  logic signed [2*CW-1:0] p2_r, p3_r, p4_r, p5_r;
  // s3: determinants
  logic v3_r;
  logic [7:0][CW-1:0] c3_r;
  logic signed [DA-1:0] dax3_r, day3_r, dbx3_r, dby3_r;
  logic signed [DETW-1:0] det3_r;
  logic signed [D1W-1:0] d13_r, d23_r;
  // s4: numerator products
  logic v4_r;
  logic [7:0][CW-1:0] c4_r;
  logic signed [DETW-1:0] det4_r;
  logic signed [P4W-1:0] m0_r, m1_r, m2_r, m3_r;
  // s5: divider prep for crossing
  logic signed [AXW-1:0] axv, ayv;
  logic signed [NCW-1:0] nx, ny;
  logic [NCW-1:0] magx, magy;
  logic [DETW-1:0] dmag;
  logic [CXW-1:0] hx, hy, dcx;
  logic negx, negy, ovfx, ovfy, fnd4;
  lli_pkg::ctl_t c1ctl_r;
  logic [lli_pkg::LANES-1:0][DETW-1:0] c1r_r;
  logic [lli_pkg::LANES-1:0][QB-1:0] c1nq_r;
  logic [DETW-1:0] c1d_r [lli_pkg::LANES];
  logic [SW1-1:0] c1side_r;
  lli_pkg::ctl_t c1ctl_o;
  logic [lli_pkg::LANES-1:0][QB-1:0] c1q_o;
  logic [SW1-1:0] c1side_o;
  // s6: saturated crossing
  logic f6, nx6, ox6, ny6, oy6;
  logic [7:0][CW-1:0] c6;
  logic [lli_pkg::OUT_W:0] sx, sy;
  logic v6_r, f6_r, clip6_r;
  logic [7:0][CW-1:0] c6_r;
  logic signed [lli_pkg::OUT_W-1:0] cx6_r, cy6_r;
  // s7: projection products
  logic signed [DA-1:0] lxa, lya, lxb, lyb;
  logic signed [VW-1:0] vxa, vya, vxb, vyb;
  logic v7_r, f7_r, clip7_r;
  logic signed [lli_pkg::OUT_W-1:0] cx7_r, cy7_r;
  logic signed [PDW-1:0] ta0_r, ta1_r, tb0_r, tb1_r;
  logic signed [P2W-1:0] la0_r, la1_r, lb0_r, lb1_r;
  // s8: divider prep for projection
  logic signed [DOTW-1:0] dota, dotb;
  logic signed [QLW-1:0] qla, qlb;
  logic signed [NPW-1:0] npa, npb;
  logic [NPW-1:0] maga, magb;
  logic [QDW-1:0] qda, qdb;
  logic [CPW-1:0] ha, hb, dca, dcb;
  logic nega, negb, ovfa, ovfb;
  lli_pkg::ctl_t c2ctl_r;
  logic [lli_pkg::LANES-1:0][QDW-1:0] c2r_r;
  logic [lli_pkg::LANES-1:0][QB-1:0] c2nq_r;
  logic [QDW-1:0] c2d_r [lli_pkg::LANES];
  logic [SW2-1:0] c2side_r;
  lli_pkg::ctl_t c2ctl_o;
  logic [lli_pkg::LANES-1:0][QB-1:0] c2q_o;
  logic [SW2-1:0] c2side_o;
  // s9: output
  logic f9, clc9, na9, oa9, nb9, ob9;
  logic [lli_pkg::OUT_W-1:0] cx9, cy9;
  logic [lli_pkg::OUT_W:0] sa, sb;
  logic out_valid_r, out_found_r, out_saturated_r;
  logic signed [lli_pkg::OUT_W-1:0] out_cross_x_r, out_cross_y_r, out_param_a_r, out_param_b_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      c1ctl_r <= '0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      c2ctl_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= start && !busy;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      c1ctl_r.valid <= v4_r;
      v6_r <= c1ctl_o.valid;
      v7_r <= v6_r;
      c2ctl_r.valid <= v7_r;
      out_valid_r <= c2ctl_o.valid;
    end
  end

  always_comb begin
    dax = DA'($signed(c1_r[0])) - DA'($signed(c1_r[2]));
    day = DA'($signed(c1_r[1])) - DA'($signed(c1_r[3]));
    dbx = DA'($signed(c1_r[4])) - DA'($signed(c1_r[6]));
    dby = DA'($signed(c1_r[5])) - DA'($signed(c1_r[7]));
  end

  always_comb begin
    axv = AXW'(m0_r) - AXW'(m1_r);
    ayv = AXW'(m2_r) - AXW'(m3_r);
    nx = NCW'(axv) <<< CF;
    ny = NCW'(ayv) <<< CF;
    magx = nx[NCW-1] ? -nx : nx;
    magy = ny[NCW-1] ? -ny : ny;
    dmag = det4_r[DETW-1] ? -det4_r : det4_r;
    negx = nx[NCW-1] ^ det4_r[DETW-1];
    negy = ny[NCW-1] ^ det4_r[DETW-1];
    hx = CXW'(magx[NCW-1:QB]);
    hy = CXW'(magy[NCW-1:QB]);
    dcx = CXW'(dmag);
    ovfx = hx >= dcx;
    ovfy = hy >= dcx;
    fnd4 = det4_r != '0;
  end

  always_comb begin
    {f6, nx6, ox6, ny6, oy6, c6} = c1side_o;
    sx = sat32(c1q_o[0], nx6, ox6);
    sy = sat32(c1q_o[1], ny6, oy6);
  end

  always_comb begin
    lxa = DA'($signed(c6_r[2])) - DA'($signed(c6_r[0]));
    lya = DA'($signed(c6_r[3])) - DA'($signed(c6_r[1]));
    lxb = DA'($signed(c6_r[6])) - DA'($signed(c6_r[4]));
    lyb = DA'($signed(c6_r[7])) - DA'($signed(c6_r[5]));
    vxa = VW'(cx6_r) - (VW'($signed(c6_r[0])) <<< CF);
    vya = VW'(cy6_r) - (VW'($signed(c6_r[1])) <<< CF);
    vxb = VW'(cx6_r) - (VW'($signed(c6_r[4])) <<< CF);
    vyb = VW'(cy6_r) - (VW'($signed(c6_r[5])) <<< CF);
  end

  always_comb begin
    dota = DOTW'(ta0_r) + DOTW'(ta1_r);
    dotb = DOTW'(tb0_r) + DOTW'(tb1_r);
    qla = QLW'(la0_r) + QLW'(la1_r);
    qlb = QLW'(lb0_r) + QLW'(lb1_r);
    npa = NPW'(dota) <<< FRAC_BITS;
    npb = NPW'(dotb) <<< FRAC_BITS;
    maga = npa[NPW-1] ? -npa : npa;
    magb = npb[NPW-1] ? -npb : npb;
    nega = npa[NPW-1];
    negb = npb[NPW-1];
    qda = {qla[2*DA-1:0], {CF{1'b0}}};
    qdb = {qlb[2*DA-1:0], {CF{1'b0}}};
    ha = CPW'(maga[NPW-1:QB]);
    hb = CPW'(magb[NPW-1:QB]);
    dca = CPW'(qda);
    dcb = CPW'(qdb);
    ovfa = ha >= dca;
    ovfb = hb >= dcb;
  end

  always_comb begin
    {f9, clc9, cx9, cy9, na9, oa9, nb9, ob9} = c2side_o;
    sa = sat32(c2q_o[0], na9, oa9);
    sb = sat32(c2q_o[1], nb9, ob9);
  end

  always_ff @(posedge clk) begin
    c1_r[0] <= crd(in_a_start_x);
    c1_r[1] <= crd(in_a_start_y);
    c1_r[2] <= crd(in_a_end_x);
    c1_r[3] <= crd(in_a_end_y);
    c1_r[4] <= crd(in_b_start_x);
    c1_r[5] <= crd(in_b_start_y);
    c1_r[6] <= crd(in_b_end_x);
    c1_r[7] <= crd(in_b_end_y);

    c2_r <= c1_r;
    dax2_r <= dax;
    day2_r <= day;
    dbx2_r <= dbx;
    dby2_r <= dby;
    p0_r <= P2W'(dax) * P2W'(dby);
    p1_r <= P2W'(day) * P2W'(dbx);
    p2_r <= (2*CW)'($signed(c1_r[0])) * (2*CW)'($signed(c1_r[3]));
    p3_r <= (2*CW)'($signed(c1_r[1])) * (2*CW)'($signed(c1_r[2]));
    p4_r <= (2*CW)'($signed(c1_r[4])) * (2*CW)'($signed(c1_r[7]));
    p5_r <= (2*CW)'($signed(c1_r[5])) * (2*CW)'($signed(c1_r[6]));

    c3_r <= c2_r;
    dax3_r <= dax2_r;
    day3_r <= day2_r;
    dbx3_r <= dbx2_r;
    dby3_r <= dby2_r;
    det3_r <= DETW'(p0_r) - DETW'(p1_r);
    d13_r <= D1W'(p2_r) - D1W'(p3_r);
    d23_r <= D1W'(p4_r) - D1W'(p5_r);

    c4_r <= c3_r;
    det4_r <= det3_r;
    m0_r <= P4W'(d13_r) * P4W'(dbx3_r);
    m1_r <= P4W'(dax3_r) * P4W'(d23_r);
    m2_r <= P4W'(d13_r) * P4W'(dby3_r);
    m3_r <= P4W'(day3_r) * P4W'(d23_r);

    c1r_r[0] <= hx[DETW-1:0];
    c1r_r[1] <= hy[DETW-1:0];
    c1nq_r[0] <= magx[QB-1:0];
    c1nq_r[1] <= magy[QB-1:0];
    c1d_r[0] <= dmag;
    c1d_r[1] <= dmag;
    c1side_r <= {fnd4, negx, ovfx, negy, ovfy, c4_r};

    f6_r <= f6;
    clip6_r <= sx[lli_pkg::OUT_W] | sy[lli_pkg::OUT_W];
    cx6_r <= sx[lli_pkg::OUT_W-1:0];
    cy6_r <= sy[lli_pkg::OUT_W-1:0];
    c6_r <= c6;

    f7_r <= f6_r;
    clip7_r <= clip6_r;
    cx7_r <= cx6_r;
    cy7_r <= cy6_r;
    ta0_r <= PDW'(lxa) * PDW'(vxa);
    ta1_r <= PDW'(lya) * PDW'(vya);
    tb0_r <= PDW'(lxb) * PDW'(vxb);
    tb1_r <= PDW'(lyb) * PDW'(vyb);
    la0_r <= P2W'(lxa) * P2W'(lxa);
    la1_r <= P2W'(lya) * P2W'(lya);
    lb0_r <= P2W'(lxb) * P2W'(lxb);
    lb1_r <= P2W'(lyb) * P2W'(lyb);

    c2r_r[0] <= ha[QDW-1:0];
    c2r_r[1] <= hb[QDW-1:0];
    c2nq_r[0] <= maga[QB-1:0];
    c2nq_r[1] <= magb[QB-1:0];
    c2d_r[0] <= qda;
    c2d_r[1] <= qdb;
    c2side_r <= {f7_r, clip7_r, cx7_r, cy7_r, nega, ovfa, negb, ovfb};

    out_found_r <= f9;
    out_cross_x_r <= f9 ? cx9 : '0;
    out_cross_y_r <= f9 ? cy9 : '0;
    out_param_a_r <= f9 ? sa[lli_pkg::OUT_W-1:0] : '0;
    out_param_b_r <= f9 ? sb[lli_pkg::OUT_W-1:0] : '0;
    out_saturated_r <= f9 & (clc9 | sa[lli_pkg::OUT_W] | sb[lli_pkg::OUT_W]);
  end

  lli_div_chain #(.DW(DETW), .SW(SW1)) u_div_cross (
    .clk(clk), .rst_n(rst_n),
    .ctl_i(c1ctl_r), .r_i(c1r_r), .nq_i(c1nq_r), .d_i(c1d_r), .side_i(c1side_r),
    .ctl_o(c1ctl_o), .q_o(c1q_o), .side_o(c1side_o)
  );

  lli_div_chain #(.DW(QDW), .SW(SW2)) u_div_proj (
    .clk(clk), .rst_n(rst_n),
    .ctl_i(c2ctl_r), .r_i(c2r_r), .nq_i(c2nq_r), .d_i(c2d_r), .side_i(c2side_r),
    .ctl_o(c2ctl_o), .q_o(c2q_o), .side_o(c2side_o)
  );

  assign out_valid = out_valid_r;
  assign out_found = out_found_r;
  assign out_cross_x = out_cross_x_r;
  assign out_cross_y = out_cross_y_r;
  assign out_param_a = out_param_a_r;
  assign out_param_b = out_param_b_r;
  assign out_saturated = out_saturated_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("beat lost in pipeline");

  a_parallel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_cross_x == '0 && out_cross_y == '0 &&
      out_param_a == '0 && out_param_b == '0 && !out_saturated))
    else $error("parallel result not cleared");

  a_sat_found: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturated) |-> out_found)
    else $error("saturation without intersection");
endmodule

/* verif/line_intersection_with_params_unit_chk.sv */
// Checker: predicts line intersection results and compares each output beat.
`timescale 1ns / 1ps
module line_intersection_with_params_unit_chk (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic                             busy,
  input  logic signed [lli_pkg::IN_W-1:0]  in_a_start_x,
  input  logic signed [lli_pkg::IN_W-1:0]  in_a_start_y,
  input  logic signed [lli_pkg::IN_W-1:0]  in_a_end_x,
  input  logic signed [lli_pkg::IN_W-1:0]  in_a_end_y,
  input  logic signed [lli_pkg::IN_W-1:0]  in_b_start_x,
  input  logic signed [lli_pkg::IN_W-1:0]  in_b_start_y,
  input  logic signed [lli_pkg::IN_W-1:0]  in_b_end_x,
  input  logic signed [lli_pkg::IN_W-1:0]  in_b_end_y,
  input  logic                             out_valid,
  input  logic                             out_found,
  input  logic signed [lli_pkg::OUT_W-1:0] out_cross_x,
  input  logic signed [lli_pkg::OUT_W-1:0] out_cross_y,
  input  logic signed [lli_pkg::OUT_W-1:0] out_param_a,
  input  logic signed [lli_pkg::OUT_W-1:0] out_param_b,
  input  logic                             out_saturated,
  output int                               fail_count,
  output int                               pending,
  output int                               found_count,
  output int                               sat_count
);
  typedef struct {
    logic found;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] pa;
    logic signed [31:0] pb;
    logic sat;
  } crossing_t;

  crossing_t crossing_q[$];

  function automatic logic signed [31:0] clip32(logic signed [127:0] v, inout logic sat);
    if (v > 128'sh7FFFFFFF) begin
      sat = 1'b1;
      return 32'sh7FFFFFFF;
    end
    if (v < -128'sh80000000) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [127:0] quot(logic signed [127:0] n, logic signed [127:0] d);
    logic [127:0] un, ud, q;
    un = n[127] ? -n : n;
    ud = d[127] ? -d : d;
    q = un / ud;
    return (n[127] != d[127]) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] line_param(
      logic signed [127:0] sx, logic signed [127:0] sy,
      logic signed [127:0] ex, logic signed [127:0] ey,
      logic signed [127:0] px, logic signed [127:0] py, inout logic sat);
    logic signed [127:0] lx, ly, qlen, dotp;
    lx = ex - sx;
    ly = ey - sy;
    qlen = lx * lx + ly * ly;
    if (qlen == 0) return 32'sd0;
    dotp = lx * (px - sx * 256) + ly * (py - sy * 256);
    return clip32(quot(dotp <<< 16, qlen <<< lli_pkg::CROSS_FRAC), sat);
  endfunction

  function automatic crossing_t predict_crossing(
      logic signed [127:0] a1x, logic signed [127:0] a1y,
      logic signed [127:0] a2x, logic signed [127:0] a2y,
      logic signed [127:0] b1x, logic signed [127:0] b1y,
      logic signed [127:0] b2x, logic signed [127:0] b2y);
    crossing_t r;
    logic signed [127:0] dax, day, dbx, dby, det, d1, d2, nx, ny;
    logic sat;
    r = '{1'b0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0};
    sat = 1'b0;
    dax = a1x - a2x;
    day = a1y - a2y;
    dbx = b1x - b2x;
    dby = b1y - b2y;
    det = dax * dby - day * dbx;
    if (det == 0) return r;
    d1 = a1x * a2y - a1y * a2x;
    d2 = b1x * b2y - b1y * b2x;
    nx = d1 * dbx - dax * d2;
    ny = d1 * dby - day * d2;
    r.found = 1'b1;
    r.cx = clip32(quot(nx <<< lli_pkg::CROSS_FRAC, det), sat);
    r.cy = clip32(quot(ny <<< lli_pkg::CROSS_FRAC, det), sat);
    r.pa = line_param(a1x, a1y, a2x, a2y, r.cx, r.cy, sat);
    r.pb = line_param(b1x, b1y, b2x, b2y, r.cx, r.cy, sat);
    r.sat = sat;
    return r;
  endfunction

  always @(posedge clk) begin
    crossing_t e;
    if (!rst_n) begin
      fail_count <= 0;
      found_count <= 0;
      sat_count <= 0;
      crossing_q.delete();
    end else begin
      if (start && !busy)
        crossing_q.push_back(predict_crossing(in_a_start_x, in_a_start_y, in_a_end_x,
            in_a_end_y, in_b_start_x, in_b_start_y, in_b_end_x, in_b_end_y));
      if (out_valid) begin
        if (crossing_q.size() == 0) begin
          $error("unexpected result beat");
          fail_count <= fail_count + 1;
        end else begin
          e = crossing_q.pop_front();
          if (e.found) found_count <= found_count + 1;
          if (e.sat) sat_count <= sat_count + 1;
          if (out_found !== e.found || out_cross_x !== e.cx || out_cross_y !== e.cy ||
              out_param_a !== e.pa || out_param_b !== e.pb || out_saturated !== e.sat)
            fail_count <= fail_count + 1;
          if (out_found !== e.found)
            $error("found: expected %0d actual %0d", e.found, out_found);
          if (out_cross_x !== e.cx)
            $error("cross_x: expected %0d actual %0d", e.cx, out_cross_x);
          if (out_cross_y !== e.cy)
            $error("cross_y: expected %0d actual %0d", e.cy, out_cross_y);
          if (out_param_a !== e.pa)
            $error("param_a: expected %0d actual %0d", e.pa, out_param_a);
          if (out_param_b !== e.pb)
            $error("param_b: expected %0d actual %0d", e.pb, out_param_b);
          if (out_saturated !== e.sat)
            $error("saturated: expected %0d actual %0d", e.sat, out_saturated);
        end
      end
    end
  end

  assign pending = crossing_q.size();
endmodule

/* verif/line_intersection_with_params_unit_test.sv */
// Testbench top: drives line pairs into the intersection unit and gives the verdict.
`timescale 1ns / 1ps
module line_intersection_with_params_unit_test;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] ax1 = '0, ay1 = '0, ax2 = '0, ay2 = '0;
  logic signed [15:0] bx1 = '0, by1 = '0, bx2 = '0, by2 = '0;
  logic out_valid, out_found, out_saturated;
  logic signed [31:0] out_cross_x, out_cross_y, out_param_a, out_param_b;
  int fail_count, pending, found_count, sat_count;
  int cycles = 0;
  int beats = 0;

  localparam int LIMIT = 200000;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  line_intersection_with_params_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_start_x(ax1), .in_a_start_y(ay1), .in_a_end_x(ax2), .in_a_end_y(ay2),
    .in_b_start_x(bx1), .in_b_start_y(by1), .in_b_end_x(bx2), .in_b_end_y(by2),
    .out_valid(out_valid), .out_found(out_found), .out_cross_x(out_cross_x),
    .out_cross_y(out_cross_y), .out_param_a(out_param_a), .out_param_b(out_param_b),
    .out_saturated(out_saturated)
  );

  line_intersection_with_params_unit_chk u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_a_start_x(ax1), .in_a_start_y(ay1), .in_a_end_x(ax2), .in_a_end_y(ay2),
    .in_b_start_x(bx1), .in_b_start_y(by1), .in_b_end_x(bx2), .in_b_end_y(by2),
    .out_valid(out_valid), .out_found(out_found), .out_cross_x(out_cross_x),
    .out_cross_y(out_cross_y), .out_param_a(out_param_a), .out_param_b(out_param_b),
    .out_saturated(out_saturated), .fail_count(fail_count), .pending(pending),
    .found_count(found_count), .sat_count(sat_count)
  );

  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 40)) - 20);
      2: return $urandom_range(0, 1) ? 16'sh7FFF - 16'($urandom_range(0, 3))
                                     : 16'sh8000 + 16'($urandom_range(0, 3));
      default: return 16'($signed($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  task automatic send_lines(input logic signed [15:0] p0, p1, p2, p3, p4, p5, p6, p7,
                            input bit allow_gap);
    int gap;
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    {ax1, ay1, ax2, ay2, bx1, by1, bx2, by2} <= {p0, p1, p2, p3, p4, p5, p6, p7};
    @(posedge clk);
    while (busy) @(posedge clk);
    beats++;
    @(negedge clk);
  endtask

  task automatic send_random(input bit allow_gap);
    logic signed [15:0] c[8];
    foreach (c[i]) c[i] = rand_coord();
    // make some pairs parallel by reusing the first direction
    if ($urandom_range(0, 7) == 0) begin
      c[6] = c[4] + (c[2] - c[0]);
      c[7] = c[5] + (c[3] - c[1]);
    end
    send_lines(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], allow_gap);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_lines(0, 0, 10, 10, 0, 10, 10, 0, 0);
    send_lines(0, 0, 10, 0, 0, 5, 10, 5, 0);
    send_lines(3, 3, 3, 3, 1, 2, 5, 7, 0);
    send_lines(0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_lines(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 0);
    send_lines(32767, 32767, 32767, 32767, 0, 0, 1, 0, 0);
    send_lines(-32768, 0, -32767, 1, 32767, 0, 32767, 1, 0);
    send_lines(0, 0, 1, 1, 0, 1, 32767, 0, 0);
    send_lines(0, 0, 3, 1, 1, 0, 0, 3, 0);
    send_lines(-1, -1, -32768, 32767, 32767, -32768, 1, 2, 0);
    send_lines(0, 0, 1, 0, 0, 1, 1, 0, 0);
    send_lines(-32768, -32768, -32767, -32767, 32767, -32768, 32766, -32767, 0);
    send_lines(16'sh5555, 16'shAAAA, 16'shAAAA, 16'sh5555, 1, 0, 0, 1, 0);
    repeat (150) send_random(1);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (200) send_random(1);
    repeat (60) send_random(0);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
    $display("covered %0d line pairs: %0d crossing, %0d clipped", beats, found_count,
             sat_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
